### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked only while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked property, also checked around reset.
`define ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### rtl/core/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg
// Types and constants of the gradient ramp sampler.
// ----------------------------------------------------------------------------
package grs_pkg;

  localparam int MAX_STOPS   = 8;
  localparam int IDX_W       = $clog2(MAX_STOPS);
  localparam int CNT_W       = 4;
  localparam int POS_W       = 16;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int PROD_W      = CH_W + POS_W;
  localparam int REM_W       = PROD_W + 1;
  localparam int DIV_STEPS   = CH_W;
  localparam int DCNT_W      = $clog2(DIV_STEPS + 1);
  // depth must stay a power of two: pointers wrap by overflow
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] STOP_COUNT_RST = CNT_W'(2);
  localparam logic [CNT_W-1:0] STOP_COUNT_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] STOP_COUNT_MAX = CNT_W'(MAX_STOPS);

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  // channel 0 red, 1 green, 2 blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] color_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    color_t           rgb;
  } stop_t;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    color_t           rgb;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

### rtl/core/gradient_ramp_sampler.sv
// ----------------------------------------------------------------------------
// gradient_ramp_sampler
// Piecewise linear color gradient over up to eight stops.
// ----------------------------------------------------------------------------
// Input words either write one stop (req_type 0) or sample the ramp
// (req_type 1); only samples return a word. Words pass through a two-entry
// queue, so the input side keeps taking words until it is full, also while
// the back end works or the output is stalled. A stop write is done in the
// idle state as its word leaves the queue. A sample at or beyond the first
// or last stop takes that stop's color; else the scan makes one table read
// per segment until it finds the one that holds the sample, and 8 steps of
// the three-lane divider blend its colors. A zero-length segment skips the
// divider, and a scan that finds no segment returns the last color.
// Results leave in input order from an output register.
// ----------------------------------------------------------------------------
module gradient_ramp_sampler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [grs_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [grs_pkg::IDX_W-1:0]  stop_index_i,
  input  logic [grs_pkg::POS_W-1:0]  stop_position_i,
  input  logic [grs_pkg::CH_W-1:0]   stop_red_i,
  input  logic [grs_pkg::CH_W-1:0]   stop_green_i,
  input  logic [grs_pkg::CH_W-1:0]   stop_blue_i,
  input  logic [grs_pkg::POS_W-1:0]  sample_position_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [grs_pkg::CH_W-1:0]   out_red_o,
  output logic [grs_pkg::CH_W-1:0]   out_green_o,
  output logic [grs_pkg::CH_W-1:0]   out_blue_o
);

  grs_pkg::qhead_t  q_head;
  logic             q_pop;
  grs_pkg::color_t  out_color;

  grs_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .stop_index_i      (stop_index_i),
    .stop_position_i   (stop_position_i),
    .stop_red_i        (stop_red_i),
    .stop_green_i      (stop_green_i),
    .stop_blue_i       (stop_blue_i),
    .sample_position_i (sample_position_i),
    .q_head_o          (q_head),
    .q_pop_i           (q_pop)
  );

  grs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_color_o (out_color)
  );

  assign out_red_o   = out_color[0];
  assign out_green_o = out_color[1];
  assign out_blue_o  = out_color[2];

endmodule

### rtl/core/grs_front.sv
// ----------------------------------------------------------------------------
// grs_front
// Accepts input words, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module grs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [grs_pkg::IDX_W-1:0]  stop_index_i,
  input  logic [grs_pkg::POS_W-1:0]  stop_position_i,
  input  logic [grs_pkg::CH_W-1:0]   stop_red_i,
  input  logic [grs_pkg::CH_W-1:0]   stop_green_i,
  input  logic [grs_pkg::CH_W-1:0]   stop_blue_i,
  input  logic [grs_pkg::POS_W-1:0]  sample_position_i,
  output grs_pkg::qhead_t            q_head_o,
  input  logic                       q_pop_i
);

  grs_pkg::cmd_t                    in_cmd;
  grs_pkg::cmd_t                    entries_q [grs_pkg::QUEUE_DEPTH];
  logic [grs_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [grs_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [grs_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                             full;
  logic                             push;
  logic                             pop;

  // keep only the position the command needs
  always_comb begin
    in_cmd.op  = grs_pkg::op_e'(req_type_i);
    in_cmd.idx = stop_index_i;
    in_cmd.pos = (in_cmd.op == grs_pkg::OP_SAMPLE) ? sample_position_i : stop_position_i;
    in_cmd.rgb = {stop_blue_i, stop_green_i, stop_red_i};
  end

  assign full       = (count_q == grs_pkg::QCNT_W'(grs_pkg::QUEUE_DEPTH));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign pop        = q_pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= in_cmd;
    end
  end

  assign q_head_o.valid = (count_q != '0);
  assign q_head_o.cmd   = entries_q[rd_ptr_q];

endmodule

### rtl/core/grs_div.sv
// ----------------------------------------------------------------------------
// grs_div
// Three-lane restoring divider for the rounded channel blend.
// ----------------------------------------------------------------------------
module grs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  grs_pkg::color_t            ca_i,
  input  grs_pkg::color_t            cb_i,
  input  logic [grs_pkg::POS_W-1:0]  span_i,
  input  logic [grs_pkg::POS_W-1:0]  off_i,
  input  logic [grs_pkg::POS_W-1:0]  spo_i,
  output grs_pkg::div_stat_t         stat_o,
  output grs_pkg::color_t            quot_o
);

  logic [grs_pkg::REM_W-1:0]   rem_q   [grs_pkg::NUM_CH];
  logic [grs_pkg::REM_W-1:0]   rem_d   [grs_pkg::NUM_CH];
  logic [grs_pkg::PROD_W-1:0]  num     [grs_pkg::NUM_CH];
  logic [grs_pkg::REM_W-1:0]   dsh_q, dsh_d;
  logic [grs_pkg::DCNT_W-1:0]  cnt_q, cnt_d;
  grs_pkg::color_t             quot_q, quot_d;

  // quotient is at most 255 since num <= 255 * span, so 8 steps suffice
  always_comb begin
    dsh_d  = dsh_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    for (int c = 0; c < grs_pkg::NUM_CH; c++) begin
      num[c]   = grs_pkg::PROD_W'(ca_i[c]) * grs_pkg::PROD_W'(spo_i)
               + grs_pkg::PROD_W'(cb_i[c]) * grs_pkg::PROD_W'(off_i);
      rem_d[c] = rem_q[c];
    end
    if (start_i) begin
      dsh_d = grs_pkg::REM_W'({span_i, 1'b0}) << (grs_pkg::DIV_STEPS - 1);
      cnt_d = grs_pkg::DCNT_W'(grs_pkg::DIV_STEPS);
      for (int c = 0; c < grs_pkg::NUM_CH; c++) begin
        rem_d[c] = {num[c], 1'b0} + grs_pkg::REM_W'(span_i);
      end
    end else if (cnt_q != '0) begin
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 1'b1;
      for (int c = 0; c < grs_pkg::NUM_CH; c++) begin
        if (rem_q[c] >= dsh_q) begin
          rem_d[c]  = rem_q[c] - dsh_q;
          quot_d[c] = {quot_q[c][grs_pkg::CH_W-2:0], 1'b1};
        end else begin
          quot_d[c] = {quot_q[c][grs_pkg::CH_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
    for (int c = 0; c < grs_pkg::NUM_CH; c++) begin
      rem_q[c] <= rem_d[c];
    end
  end

  assign stat_o.done = (cnt_q == grs_pkg::DCNT_W'(1));
  assign quot_o      = quot_q;

endmodule

### rtl/core/grs_back.sv
// ----------------------------------------------------------------------------
// grs_back
// Holds the stop table and carries out writes and samples from the queue.
// ----------------------------------------------------------------------------
module grs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [grs_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  grs_pkg::qhead_t            q_head_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output grs_pkg::color_t            out_color_o
);

  grs_pkg::state_e               state_q, state_d;
  logic [grs_pkg::CNT_W-1:0]     stop_count_q;
  logic [grs_pkg::CNT_W-1:0]     n_sat;
  logic [grs_pkg::IDX_W-1:0]     last_idx;
  grs_pkg::stop_t                stops_q [grs_pkg::MAX_STOPS];
  logic [grs_pkg::IDX_W-1:0]     rd_idx;
  grs_pkg::stop_t                rd_entry;
  grs_pkg::stop_t                a_q;
  grs_pkg::color_t               b_rgb_q;
  grs_pkg::color_t               last_rgb_q;
  grs_pkg::color_t               res_q;
  grs_pkg::color_t               out_q;
  logic [grs_pkg::POS_W-1:0]     pos_q;
  logic [grs_pkg::POS_W-1:0]     span_q, off_q, spo_q;
  logic [grs_pkg::IDX_W-1:0]     idx_q;
  logic [grs_pkg::IDX_W-1:0]     nxt_idx;
  logic                          res_div_q;
  logic                          out_valid_q;
  logic                          clamp_lo, clamp_hi, seg_hit, scan_end;
  logic                          out_free;
  logic                          tbl_we;
  logic                          div_start;
  logic                          out_fire;
  grs_pkg::div_stat_t            div_stat;
  grs_pkg::color_t               div_quot;

  // saturate the stop count to the legal range
  always_comb begin
    n_sat = stop_count_q;
    if (stop_count_q < grs_pkg::STOP_COUNT_MIN) begin
      n_sat = grs_pkg::STOP_COUNT_MIN;
    end else if (stop_count_q > grs_pkg::STOP_COUNT_MAX) begin
      n_sat = grs_pkg::STOP_COUNT_MAX;
    end
  end

  assign last_idx = grs_pkg::IDX_W'(n_sat - 1'b1);
  assign nxt_idx  = idx_q + 1'b1;
  assign rd_entry = stops_q[rd_idx];
  assign clamp_lo = (pos_q <= a_q.pos);
  assign clamp_hi = (pos_q >= rd_entry.pos);
  assign seg_hit  = (pos_q >= a_q.pos) && (pos_q <= rd_entry.pos);
  assign scan_end = (nxt_idx == last_idx);
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      grs_pkg::ST_IDLE: begin
        if (q_head_i.valid && q_head_i.cmd.op == grs_pkg::OP_SAMPLE) begin
          state_d = grs_pkg::ST_RD_FIRST;
        end
      end
      grs_pkg::ST_RD_FIRST: begin
        state_d = grs_pkg::ST_RD_LAST;
      end
      grs_pkg::ST_RD_LAST: begin
        state_d = (clamp_lo || clamp_hi) ? grs_pkg::ST_DONE : grs_pkg::ST_SCAN;
      end
      grs_pkg::ST_SCAN: begin
        if (seg_hit) begin
          state_d = grs_pkg::ST_MUL;
        end else if (scan_end) begin
          state_d = grs_pkg::ST_DONE;
        end
      end
      grs_pkg::ST_MUL: begin
        state_d = (span_q == '0) ? grs_pkg::ST_DONE : grs_pkg::ST_DIV;
      end
      grs_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = grs_pkg::ST_DONE;
        end
      end
      grs_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = grs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = grs_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o   = 1'b0;
    tbl_we    = 1'b0;
    div_start = 1'b0;
    out_fire  = 1'b0;
    rd_idx    = '0;
    case (state_q)
      grs_pkg::ST_IDLE: begin
        q_pop_o = q_head_i.valid;
        tbl_we  = q_head_i.valid && (q_head_i.cmd.op == grs_pkg::OP_WRITE);
      end
      grs_pkg::ST_RD_LAST: begin
        rd_idx = last_idx;
      end
      grs_pkg::ST_SCAN: begin
        rd_idx = nxt_idx;
      end
      grs_pkg::ST_MUL: begin
        div_start = (span_q != '0);
      end
      grs_pkg::ST_DONE: begin
        out_fire = out_free;
      end
      default: begin
        rd_idx = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= grs_pkg::ST_IDLE;
      stop_count_q <= grs_pkg::STOP_COUNT_RST;
      out_valid_q  <= 1'b0;
      res_div_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        stop_count_q <= cfg_wdata_i;
      end
      if (out_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == grs_pkg::ST_IDLE) begin
        res_div_q <= 1'b0;
      end else if (state_q == grs_pkg::ST_DIV) begin
        res_div_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      stops_q[q_head_i.cmd.idx] <= {q_head_i.cmd.pos, q_head_i.cmd.rgb};
    end
    if (out_fire) begin
      out_q <= res_div_q ? div_quot : res_q;
    end
    case (state_q)
      grs_pkg::ST_IDLE: begin
        pos_q <= q_head_i.cmd.pos;
      end
      grs_pkg::ST_RD_FIRST: begin
        a_q <= rd_entry;
      end
      grs_pkg::ST_RD_LAST: begin
        last_rgb_q <= rd_entry.rgb;
        idx_q      <= '0;
        res_q      <= clamp_lo ? a_q.rgb : rd_entry.rgb;
      end
      grs_pkg::ST_SCAN: begin
        if (seg_hit) begin
          span_q  <= rd_entry.pos - a_q.pos;
          off_q   <= pos_q - a_q.pos;
          spo_q   <= rd_entry.pos - pos_q;
          b_rgb_q <= rd_entry.rgb;
        end else begin
          // advance to the next segment; fall back to the last color
          a_q   <= rd_entry;
          idx_q <= nxt_idx;
          res_q <= last_rgb_q;
        end
      end
      grs_pkg::ST_MUL: begin
        res_q <= a_q.rgb;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  grs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .ca_i    (a_q.rgb),
    .cb_i    (b_rgb_q),
    .span_i  (span_q),
    .off_i   (off_q),
    .spo_i   (spo_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_color_o = out_q;

endmodule

### rtl/core/grs_checker.sv
// ----------------------------------------------------------------------------
// grs_checker
// Port-level checks on the gradient ramp sampler.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grs_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_o,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic [grs_pkg::CH_W-1:0]   out_red_o,
  input  logic [grs_pkg::CH_W-1:0]   out_green_o,
  input  logic [grs_pkg::CH_W-1:0]   out_blue_o
);

  // no word may be pending right out of reset
  `ASSERT_RST(a_out_idle_after_reset, clk_i, $rose(rst_ni) |-> !out_valid_o)

  // the queue fills only by taking a word
  `ASSERT_CLK(a_stall_needs_push, clk_i, rst_ni, $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))

  `ASSERT_CLK(a_out_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)

  `ASSERT_CLK(a_out_word_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o))

endmodule

bind gradient_ramp_sampler grs_checker u_grs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_red_o   (out_red_o),
  .out_green_o (out_green_o),
  .out_blue_o  (out_blue_o)
);
